@@ design/p2plm_pkg.sv @@
// shared types and constants of the peak-to-peak level meter
// no dependencies
`timescale 1ns / 1ps

package p2plm_pkg;

    localparam int FRAME_SAMPLES = 512;
    localparam int SAMPLE_POS_W  = $clog2(FRAME_SAMPLES);

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 24;
    localparam int TOTAL_W  = 56;
    localparam int COUNT_W  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_DIVIDEND_W = TOTAL_W;
    localparam int DIV_DIVISOR_W  = COUNT_W;
    localparam int DIV_STEPS      = DIV_DIVIDEND_W;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_WINDOW_FRAMES = 2'd0;
    localparam logic [1:0] REG_USE_MIC_SCALE = 2'd1;
    localparam logic [1:0] REG_MIC_DIVISOR   = 2'd2;
    localparam logic [1:0] REG_HUMAN_DIVISOR = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEVEL,
        S_UPDATE,
        S_MEAN,
        S_EMIT
    } t_back_state;

endpackage

@@ design/p2plm_front.sv @@
// sample front end: per-frame min/max tracking and window summing
// depends on p2plm_pkg
`timescale 1ns / 1ps

module p2plm_front import p2plm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_in_ready,
    input  logic                       i_q_full,
    input  logic [7:0]                 i_window_frames,
    output logic                       o_q_push,
    output logic [LEVEL_W-1:0]         o_q_data
);

    logic signed [SAMPLE_W-1:0] r_low;
    logic signed [SAMPLE_W-1:0] r_high;
    logic [SAMPLE_POS_W-1:0]    r_spos;
    logic [7:0]                 r_fpos;
    logic [LEVEL_W-1:0]         r_sum;

    logic signed [SAMPLE_W-1:0] n_low;
    logic signed [SAMPLE_W-1:0] n_high;
    logic [SAMPLE_W:0]          span_full;
    logic [SAMPLE_W-1:0]        span;
    logic [LEVEL_W:0]           sum_full;
    logic [LEVEL_W-1:0]         n_sum;
    logic [7:0]                 limit;
    logic                       accept;
    logic                       frame_end;
    logic                       win_end;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign n_low     = (i_sample < r_low) ? i_sample : r_low;
    assign n_high    = (i_sample > r_high) ? i_sample : r_high;
    assign span_full = {n_high[SAMPLE_W-1], n_high} - {n_low[SAMPLE_W-1], n_low};
    assign span      = span_full[SAMPLE_W-1:0];
    assign sum_full  = {1'b0, r_sum} + (LEVEL_W + 1)'(span);
    assign n_sum     = sum_full[LEVEL_W] ? {LEVEL_W{1'b1}} : sum_full[LEVEL_W-1:0];

    assign limit     = (i_window_frames == 8'd0) ? 8'd1 : i_window_frames;
    assign frame_end = (r_spos == SAMPLE_POS_W'(FRAME_SAMPLES - 1));
    assign win_end   = frame_end && (({1'b0, r_fpos} + 9'd1) >= {1'b0, limit});

    assign o_q_push = accept && win_end;
    assign o_q_data = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_spos <= '0;
            r_fpos <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_spos <= '0;
                r_low  <= '0;
                r_high <= '0;
                if (win_end) begin
                    r_sum  <= '0;
                    r_fpos <= '0;
                end else begin
                    r_sum  <= n_sum;
                    r_fpos <= r_fpos + 8'd1;
                end
            end else begin
                r_spos <= r_spos + SAMPLE_POS_W'(1);
                r_low  <= n_low;
                r_high <= n_high;
            end
        end
    end

endmodule

@@ design/p2plm_queue.sv @@
// short fifo of window sums between front end and back end
// depends on p2plm_pkg
`timescale 1ns / 1ps

module p2plm_queue import p2plm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [LEVEL_W-1:0] i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output logic [LEVEL_W-1:0] o_data
);

    logic [LEVEL_W-1:0]     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

@@ design/p2plm_divider.sv @@
// restoring divider, one quotient bit per clock
// depends on p2plm_pkg
`timescale 1ns / 1ps

module p2plm_divider import p2plm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIV_DIVIDEND_W-1:0] i_dividend,
    input  logic [DIV_DIVISOR_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [DIV_DIVIDEND_W-1:0] o_quotient
);

    logic                      r_busy;
    logic                      r_done;
    logic [DIV_CNT_W-1:0]      r_cnt;
    logic [DIV_DIVISOR_W-1:0]  r_rem;
    logic [DIV_DIVISOR_W-1:0]  r_div;
    logic [DIV_DIVIDEND_W-1:0] r_quo;

    logic [DIV_DIVISOR_W:0]    trial;
    logic [DIV_DIVISOR_W:0]    diff;
    logic                      ge;

    assign trial = {r_rem, r_quo[DIV_DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DIVISOR_W-1:0] : trial[DIV_DIVISOR_W-1:0];
            r_quo <= {r_quo[DIV_DIVIDEND_W-2:0], ge};
        end
    end

endmodule

@@ design/p2plm_back.sv @@
// back end: level scaling, lowest/highest/mean tracking, result register
// depends on p2plm_pkg and p2plm_divider
`timescale 1ns / 1ps

module p2plm_back import p2plm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [LEVEL_W-1:0] i_q_data,
    output logic               o_q_pop,
    input  logic [7:0]         i_window_frames,
    input  logic               i_use_mic_scale,
    input  logic [15:0]        i_mic_divisor,
    input  logic [15:0]        i_human_divisor,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LEVEL_W-1:0] o_level_now,
    output logic [LEVEL_W-1:0] o_level_lowest,
    output logic [LEVEL_W-1:0] o_level_highest,
    output logic [LEVEL_W-1:0] o_level_mean
);

    t_back_state r_state;
    t_back_state n_state;

    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_lowest;
    logic [LEVEL_W-1:0] r_highest;
    logic [TOTAL_W-1:0] r_total;
    logic [COUNT_W-1:0] r_count;
    logic [LEVEL_W-1:0] r_mean;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_now;
    logic [LEVEL_W-1:0] r_out_lowest;
    logic [LEVEL_W-1:0] r_out_highest;
    logic [LEVEL_W-1:0] r_out_mean;

    logic [TOTAL_W:0]          total_full;
    logic [TOTAL_W-1:0]        n_total;
    logic [COUNT_W-1:0]        n_count;
    logic [7:0]                frames_eff;
    logic [15:0]               div_sel;
    logic [15:0]               div_eff;
    logic [LEVEL_W-1:0]        scale;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_DIVIDEND_W-1:0] div_dividend;
    logic [DIV_DIVISOR_W-1:0]  div_divisor;
    logic [DIV_DIVIDEND_W-1:0] div_quo;
    logic                      out_load;

    assign frames_eff = (i_window_frames == 8'd0) ? 8'd1 : i_window_frames;
    assign div_sel    = i_use_mic_scale ? i_mic_divisor : i_human_divisor;
    assign div_eff    = (div_sel == 16'd0) ? 16'd1 : div_sel;
    assign scale      = LEVEL_W'(frames_eff) * LEVEL_W'(div_eff);

    assign total_full = {1'b0, r_total} + (TOTAL_W + 1)'(r_level);
    assign n_total    = total_full[TOTAL_W] ? {TOTAL_W{1'b1}} : total_full[TOTAL_W-1:0];
    assign n_count    = (r_count == {COUNT_W{1'b1}}) ? r_count : r_count + COUNT_W'(1);

    p2plm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) n_state = S_LEVEL;
            end
            S_LEVEL: begin
                if (div_done) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_MEAN;
            end
            S_MEAN: begin
                if (div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop      = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        div_dividend = DIV_DIVIDEND_W'({i_q_data, 8'd0});
        div_divisor  = DIV_DIVISOR_W'(scale);
        unique case (r_state)
            S_IDLE: begin
                o_q_pop   = !i_q_empty;
                div_start = !i_q_empty;
            end
            S_UPDATE: begin
                div_start    = 1'b1;
                div_dividend = n_total;
                div_divisor  = n_count;
            end
            S_EMIT: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lowest    <= {LEVEL_W{1'b1}};
            r_highest   <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPDATE) begin
                if (r_level < r_lowest)  r_lowest  <= r_level;
                if (r_level > r_highest) r_highest <= r_level;
                r_total <= n_total;
                r_count <= n_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // lowest and highest are updated by the time the mean pass finishes
    always_ff @(posedge i_clk) begin
        if (r_state == S_LEVEL && div_done) begin
            r_level <= (|div_quo[DIV_DIVIDEND_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}}
                                                            : div_quo[LEVEL_W-1:0];
        end
        if (r_state == S_MEAN && div_done) begin
            r_mean <= div_quo[LEVEL_W-1:0];
        end
        if (out_load) begin
            r_out_now     <= r_level;
            r_out_lowest  <= r_lowest;
            r_out_highest <= r_highest;
            r_out_mean    <= r_mean;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level_now     = r_out_now;
    assign o_level_lowest  = r_out_lowest;
    assign o_level_highest = r_out_highest;
    assign o_level_mean    = r_out_mean;

endmodule

@@ design/peak_to_peak_level_meter_core.sv @@
// top level of the peak-to-peak level meter: register port and block wiring
// depends on p2plm_pkg, p2plm_front, p2plm_queue and p2plm_back
`timescale 1ns / 1ps

// The front end takes one sample per clock and tracks each frame's minimum and maximum; it
// holds off a sample only when the two-entry window queue is full. Each closed window is
// scaled and folded into the statistics by the back end, which runs a shared 56-step
// restoring divider twice (level, then mean) to produce one result per closed window. Results
// wait in an output register while new samples keep flowing until the window queue is full.

module peak_to_peak_level_meter_core import p2plm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [LEVEL_W-1:0]         o_level_now,
    output logic [LEVEL_W-1:0]         o_level_lowest,
    output logic [LEVEL_W-1:0]         o_level_highest,
    output logic [LEVEL_W-1:0]         o_level_mean
);

    logic [7:0]  r_window_frames;
    logic        r_use_mic_scale;
    logic [15:0] r_mic_divisor;
    logic [15:0] r_human_divisor;

    logic               cfg_wr;
    logic               q_push;
    logic [LEVEL_W-1:0] q_wdata;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [LEVEL_W-1:0] q_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_frames <= 8'd5;
            r_use_mic_scale <= 1'b1;
            r_mic_divisor   <= 16'd256;
            r_human_divisor <= 16'd256;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_WINDOW_FRAMES: r_window_frames <= pwdata[7:0];
                REG_USE_MIC_SCALE: r_use_mic_scale <= pwdata[0];
                REG_MIC_DIVISOR:   r_mic_divisor   <= pwdata[15:0];
                REG_HUMAN_DIVISOR: r_human_divisor <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WINDOW_FRAMES: prdata = {24'd0, r_window_frames};
            REG_USE_MIC_SCALE: prdata = {31'd0, r_use_mic_scale};
            REG_MIC_DIVISOR:   prdata = {16'd0, r_mic_divisor};
            REG_HUMAN_DIVISOR: prdata = {16'd0, r_human_divisor};
            default:           prdata = '0;
        endcase
    end

    p2plm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_sample        (i_sample),
        .o_in_ready      (o_in_ready),
        .i_q_full        (q_full),
        .i_window_frames (r_window_frames),
        .o_q_push        (q_push),
        .o_q_data        (q_wdata)
    );

    p2plm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    p2plm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .i_window_frames (r_window_frames),
        .i_use_mic_scale (r_use_mic_scale),
        .i_mic_divisor   (r_mic_divisor),
        .i_human_divisor (r_human_divisor),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_level_now     (o_level_now),
        .o_level_lowest  (o_level_lowest),
        .o_level_highest (o_level_highest),
        .o_level_mean    (o_level_mean)
    );

    a_low_le_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_lowest <= o_level_highest))
        else $error("lowest level above highest level");

    a_now_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_now >= o_level_lowest && o_level_now <= o_level_highest))
        else $error("current level outside lowest/highest range");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for peak_to_peak_level_meter_core: sample stream in, level results out
// depends on p2plm_pkg and the core; predicts each window level with its own copy of the meter state
`timescale 1ns / 1ps

module testbench;
    import p2plm_pkg::*;

    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 4000;
    localparam int RANDOM_RESULTS_TARGET = 40;
    localparam int RANDOM_SAMPLES_TARGET = 900;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum int {
        SHAPE_FULL, SHAPE_QUIET, SHAPE_POSITIVE, SHAPE_NEGATIVE,
        SHAPE_SPIKES, SHAPE_ZERO, SHAPE_RAIL
    } t_sample_shape;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_now;
        logic [LEVEL_W-1:0] level_lowest;
        logic [LEVEL_W-1:0] level_highest;
        logic [LEVEL_W-1:0] level_mean;
    } t_meter_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [LEVEL_W-1:0]         o_level_now;
    logic [LEVEL_W-1:0]         o_level_lowest;
    logic [LEVEL_W-1:0]         o_level_highest;
    logic [LEVEL_W-1:0]         o_level_mean;

    peak_to_peak_level_meter_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_level_now    (o_level_now),
        .o_level_lowest (o_level_lowest),
        .o_level_highest(o_level_highest),
        .o_level_mean   (o_level_mean)
    );

    // shadow registers
    logic [7:0]  cfg_window_frames = 8'd5;
    logic        cfg_use_mic       = 1'b1;
    logic [15:0] cfg_mic_div       = 16'd256;
    logic [15:0] cfg_human_div     = 16'd256;

    // predicted meter state
    logic signed [SAMPLE_W-1:0] frame_low  = '0;
    logic signed [SAMPLE_W-1:0] frame_high = '0;
    int                         sample_pos = 0;
    int                         frame_pos  = 0;
    logic [LEVEL_W-1:0]         window_sum = '0;
    logic [LEVEL_W-1:0]         lowest_level  = LEVEL_MAX;
    logic [LEVEL_W-1:0]         highest_level = '0;
    logic [TOTAL_W-1:0]         level_total   = '0;
    logic [COUNT_W-1:0]         window_count  = '0;

    logic signed [SAMPLE_W-1:0] sample_q[$];
    t_meter_result              level_expect_q[$];
    t_meter_result              expected_level;

    t_idle_mode idle_mode = IDLE_NONE;
    int  samples_sent  = 0;
    int  samples_taken = 0;
    int  results_seen  = 0;
    int  settings_used = 0;
    int  error_count   = 0;
    int  hold_left     = 0;
    bit  hold_trigger  = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic void meter_take_sample(input logic signed [SAMPLE_W-1:0] pcm);
        int                 span;
        longint unsigned    sum_next;
        longint unsigned    frames;
        longint unsigned    divisor;
        longint unsigned    quotient;
        longint unsigned    total_next;
        logic [LEVEL_W-1:0] level;
        t_meter_result      r;
        if (pcm < frame_low) frame_low = pcm;
        if (pcm > frame_high) frame_high = pcm;
        sample_pos++;
        if (sample_pos < FRAME_SAMPLES) return;

        // frame closes
        span = int'(frame_high) - int'(frame_low);
        sample_pos = 0;
        frame_low = '0;
        frame_high = '0;
        sum_next = longint'(window_sum) + longint'(span);
        window_sum = (sum_next > longint'(LEVEL_MAX)) ? LEVEL_MAX : sum_next[LEVEL_W-1:0];
        frame_pos++;
        frames = (cfg_window_frames == 0) ? 1 : cfg_window_frames;
        if (frame_pos < frames) return;

        // window closes
        divisor = cfg_use_mic ? cfg_mic_div : cfg_human_div;
        if (divisor == 0) divisor = 1;
        quotient = (longint'(window_sum) << 8) / (frames * divisor);
        level = (quotient > longint'(LEVEL_MAX)) ? LEVEL_MAX : quotient[LEVEL_W-1:0];
        window_sum = '0;
        frame_pos = 0;
        if (level < lowest_level) lowest_level = level;
        if (level > highest_level) highest_level = level;
        total_next = longint'(level_total) + longint'(level);
        level_total = (total_next > longint'(TOTAL_MAX)) ? TOTAL_MAX : total_next[TOTAL_W-1:0];
        if (window_count != COUNT_MAX) window_count++;
        r.level_now     = level;
        r.level_lowest  = lowest_level;
        r.level_highest = highest_level;
        r.level_mean    = LEVEL_W'(longint'(level_total) / longint'(window_count));
        level_expect_q.push_back(r);
    endfunction

    function automatic void check_level(input string name, input logic [LEVEL_W-1:0] exp_v,
                                        input logic [LEVEL_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %06h actual %06h", $realtime, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    function automatic bit idle_roll(input bit sender_side);
        int pct;
        pct = 0;
        case (idle_mode)
            IDLE_SENDER:   pct = sender_side ? 68 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 68;
            IDLE_BOTH:     pct = 32;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // sample driver
    always @(negedge i_clk) begin
        if (i_rst_n && samples_sent == samples_taken) begin
            if (sample_q.size() != 0 && !idle_roll(1'b1)) begin
                i_sample   <= sample_q.pop_front();
                i_in_valid <= 1'b1;
                samples_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        i_out_ready <= (hold_left == 0) && !idle_roll(1'b0);
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_trigger) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                meter_take_sample(i_sample);
                samples_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (level_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %06h %06h %06h %06h",
                             $realtime, o_level_now, o_level_lowest, o_level_highest,
                             o_level_mean);
                    error_count++;
                end else begin
                    expected_level = level_expect_q.pop_front();
                    check_level("level_now", expected_level.level_now, o_level_now);
                    check_level("level_lowest", expected_level.level_lowest, o_level_lowest);
                    check_level("level_highest", expected_level.level_highest, o_level_highest);
                    check_level("level_mean", expected_level.level_mean, o_level_mean);
                end
                results_seen++;
            end
        end
    end

    task automatic apb_write(input logic [1:0] reg_index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_index)
            REG_WINDOW_FRAMES: cfg_window_frames = value[7:0];
            REG_USE_MIC_SCALE: cfg_use_mic       = value[0];
            REG_MIC_DIVISOR:   cfg_mic_div       = value[15:0];
            REG_HUMAN_DIVISOR: cfg_human_div     = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_meter(input int frames, input bit use_mic, input int mic_div,
                             input int human_div);
        apb_write(REG_WINDOW_FRAMES, 32'(frames));
        apb_write(REG_USE_MIC_SCALE, 32'(use_mic));
        apb_write(REG_MIC_DIVISOR, 32'(mic_div));
        apb_write(REG_HUMAN_DIVISOR, 32'(human_div));
        settings_used++;
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || samples_sent != samples_taken ||
               level_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] make_sample(input t_sample_shape shape);
        case (shape)
            SHAPE_QUIET:    return SAMPLE_W'(int'($urandom_range(511)) - 256);
            SHAPE_POSITIVE: return SAMPLE_W'($urandom_range(32767, 1));
            SHAPE_NEGATIVE: return SAMPLE_W'(-int'($urandom_range(32768, 1)));
            SHAPE_SPIKES: begin
                if ($urandom_range(99) < 2)
                    return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                return SAMPLE_W'(int'($urandom_range(4095)) - 2048);
            end
            SHAPE_ZERO:     return '0;
            SHAPE_RAIL:     return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default:        return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic push_samples(input int count, input t_sample_shape shape);
        for (int k = 0; k < count; k++) sample_q.push_back(make_sample(shape));
    endtask

    function automatic int pick_divisor();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(1024, 1);
        if (roll < 90) return $urandom_range(65535);
        return $urandom_range(1) ? 0 : 65535;
    endfunction

    initial begin
        int random_mark;
        int random_start;
        int frames;
        int setting;
        int roll;
        int w;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: field extremes then a five-frame window
        sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sh7FFF);
        sample_q.push_back(16'sh0000);
        sample_q.push_back(16'shFFFF);
        sample_q.push_back(16'sh0001);
        sample_q.push_back(16'sh5555);
        sample_q.push_back(16'shAAAA);
        push_samples(FRAME_SAMPLES - 7, SHAPE_ZERO);
        push_samples(FRAME_SAMPLES, SHAPE_POSITIVE);
        push_samples(FRAME_SAMPLES, SHAPE_NEGATIVE);
        push_samples(FRAME_SAMPLES, SHAPE_ZERO);
        push_samples(FRAME_SAMPLES, SHAPE_QUIET);
        wait_idle();

        // one frame per window, smallest mic divisor
        set_meter(1, 1'b1, 1, 65535);
        push_samples(FRAME_SAMPLES, SHAPE_ZERO);
        push_samples(FRAME_SAMPLES, SHAPE_RAIL);
        push_samples(FRAME_SAMPLES, SHAPE_POSITIVE);
        push_samples(FRAME_SAMPLES, SHAPE_NEGATIVE);
        push_samples(FRAME_SAMPLES, SHAPE_FULL);
        wait_idle();

        // zero window length, human divisor at its top
        set_meter(0, 1'b0, 1, 65535);
        push_samples(FRAME_SAMPLES, SHAPE_RAIL);
        push_samples(FRAME_SAMPLES, SHAPE_QUIET);
        push_samples(FRAME_SAMPLES, SHAPE_SPIKES);
        wait_idle();

        // zero mic divisor
        set_meter(2, 1'b1, 0, 1);
        push_samples(4 * FRAME_SAMPLES, SHAPE_FULL);
        wait_idle();

        // receiver holds off while samples keep coming
        set_meter(1, 1'b1, 300, 7);
        @(negedge i_clk);
        hold_trigger = 1'b1;
        @(negedge i_clk);
        hold_trigger = 1'b0;
        for (int f = 0; f < 8; f++)
            push_samples(FRAME_SAMPLES, (f % 2) ? SHAPE_RAIL : SHAPE_FULL);
        wait_idle();

        // longest window, then shortened below the frames gathered: level saturates
        set_meter(255, 1'b1, 1, 1);
        push_samples(3 * FRAME_SAMPLES, SHAPE_RAIL);
        wait_idle();
        apb_write(REG_WINDOW_FRAMES, 32'd1);
        push_samples(FRAME_SAMPLES, SHAPE_RAIL);
        wait_idle();

        // zero human divisor
        set_meter(3, 1'b0, 65535, 0);
        push_samples(3 * FRAME_SAMPLES, SHAPE_SPIKES);
        wait_idle();

        random_mark = results_seen;
        random_start = samples_taken;
        setting = 0;
        while (results_seen - random_mark < RANDOM_RESULTS_TARGET ||
               samples_taken - random_start < RANDOM_SAMPLES_TARGET) begin
            idle_mode = t_idle_mode'(setting % 4);
            roll = $urandom_range(99);
            if (roll < 60) frames = 1;
            else if (roll < 80) frames = 2;
            else if (roll < 95) frames = $urandom_range(6, 3);
            else frames = 0;
            set_meter(frames, 1'(($urandom_range(1))), pick_divisor(), pick_divisor());
            if (frames == 0) frames = 1;
            frames = frames * $urandom_range(3, 1);
            for (int f = 0; f < frames; f++)
                push_samples(FRAME_SAMPLES, t_sample_shape'($urandom_range(SHAPE_RAIL)));
            if ($urandom_range(3) == 0)
                push_samples($urandom_range(FRAME_SAMPLES - 1, 1),
                             t_sample_shape'($urandom_range(SHAPE_RAIL)));
            wait_idle();
            setting++;
        end

        idle_mode = IDLE_NONE;
        w = 0;
        while (w < 100000 && (sample_q.size() != 0 || samples_sent != samples_taken ||
                              level_expect_q.size() != 0)) begin
            @(posedge i_clk);
            w++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (level_expect_q.size() != 0) begin
            $display("%0t: %0d level results expected but never transferred", $realtime,
                     level_expect_q.size());
            error_count++;
        end

        $display("run covered %0d samples, %0d level results, %0d register settings",
                 samples_taken, results_seen, settings_used);
        $display("idle phases on both sides, a long receiver hold-off, %0d mismatches",
                 error_count);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
